/* design/isie_pkg.sv */
`default_nettype none
package isie_pkg;

	// Field widths of the item channels
	localparam int MODE_W = 2;
	localparam int POS_W  = 9;
	localparam int VAL_W  = 32;
	localparam int RCNT_W = 9;
	localparam int LEN_W  = 9;
	localparam int STAT_W = 2;

	// Default store size
	localparam int CAPACITY_DEF = 256;

	// Operation codes
	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ERASE  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_GET    = 2'd2;
	localparam logic [MODE_W-1:0] MODE_SET    = 2'd3;

	// Status codes
	localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [MODE_W-1:0]       mode;
		logic [POS_W-1:0]        position;
		logic signed [VAL_W-1:0] item_value;
		logic [RCNT_W-1:0]       remove_count;
	} req_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] read_value;
		logic [LEN_W-1:0]        length;
		logic [STAT_W-1:0]       status;
	} rsp_t;

endpackage
`default_nettype wire

/* design/isie_ram.sv */
`default_nettype none
module isie_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [$clog2(DEPTH)-1:0]  waddr,
	input  wire [WIDTH-1:0]          wdata,
	input  wire [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one word, read one word with registered data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

/* design/indexed_sequence_insert_erase_unit.sv */
`default_nettype none
// Path to the result register load: set and failed items pass the evaluate and finish states,
// a get adds a read state, an insert moves entries, an erase clamps the count and moves entries
// unless it is zero; one entry moves per cycle through the read and write ports of the memory.
// Throughput: one item at a time; the next item is taken the cycle after the result loads,
// and a stalled result register holds the sequencer in its final state.
// Reset clears the sequencer, the length and the output valid; entry memory is not cleared.
module indexed_sequence_insert_erase_unit #(
	parameter int CAPACITY = isie_pkg::CAPACITY_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  req_valid,
	output logic                 req_stall,
	input  wire isie_pkg::req_t  req,
	output logic                 rsp_valid,
	input  wire                  rsp_stall,
	output isie_pkg::rsp_t       rsp
);

	localparam int ADDR_W = $clog2(CAPACITY);
	localparam int LCNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W  = (LCNT_W > isie_pkg::POS_W) ? LCNT_W + 1 : isie_pkg::POS_W + 1;
	localparam logic [CMP_W-1:0] CAP_X = CMP_W'(CAPACITY);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EVAL  = 3'd1;
	localparam logic [2:0] S_CLAMP = 3'd2;
	localparam logic [2:0] S_MOVE  = 3'd3;
	localparam logic [2:0] S_GETRD = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;

	logic [2:0]                       state_q;
	logic [isie_pkg::MODE_W-1:0]      mode_q;
	logic [CMP_W-1:0]                 pos_q;
	logic [CMP_W-1:0]                 cnt_q;
	logic [CMP_W-1:0]                 avail_q;
	logic signed [isie_pkg::VAL_W-1:0] val_q;
	logic [LCNT_W-1:0]                len_q;
	logic [ADDR_W-1:0]                src_q;
	logic [ADDR_W-1:0]                dst_q;
	logic [LCNT_W-1:0]                left_q;
	logic                             up_q;
	logic                             rv_s1;
	logic [ADDR_W-1:0]                wdst_s1;
	logic signed [isie_pkg::VAL_W-1:0] res_value_q;
	logic [isie_pkg::STAT_W-1:0]      res_status_q;
	logic                             rsp_valid_q;
	isie_pkg::rsp_t                   rsp_q;

	logic [CMP_W-1:0]                 len_x;
	logic [CMP_W-1:0]                 ecnt;
	logic                             ram_we;
	logic [ADDR_W-1:0]                ram_waddr;
	logic [isie_pkg::VAL_W-1:0]       ram_wdata;
	logic [ADDR_W-1:0]                ram_raddr;
	logic [isie_pkg::VAL_W-1:0]       ram_rdata;
	logic                             out_free;

	assign len_x     = CMP_W'(len_q);
	assign ecnt      = (cnt_q > avail_q) ? avail_q : cnt_q;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Steer the memory ports
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wdst_s1;
		ram_wdata = ram_rdata;
		ram_raddr = src_q;
		case (state_q)
			S_EVAL: begin
				ram_raddr = pos_q[ADDR_W-1:0];
				if (mode_q == isie_pkg::MODE_SET && pos_q < len_x) begin
					ram_we    = 1'b1;
					ram_waddr = pos_q[ADDR_W-1:0];
					ram_wdata = val_q;
				end
			end
			S_MOVE: begin
				if (rv_s1) begin
					ram_we = 1'b1;
				end else if (left_q == '0 && mode_q == isie_pkg::MODE_INSERT) begin
					ram_we    = 1'b1;
					ram_waddr = pos_q[ADDR_W-1:0];
					ram_wdata = val_q;
				end
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	isie_ram #(
		.WIDTH(isie_pkg::VAL_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Hold operands of the accepted item
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			mode_q <= req.mode;
			pos_q  <= CMP_W'(req.position);
			cnt_q  <= CMP_W'(req.remove_count);
			val_q  <= req.item_value;
		end
	end

	// Sequence the operation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			len_q        <= '0;
			left_q       <= '0;
			rv_s1        <= 1'b0;
			rsp_valid_q  <= 1'b0;
			src_q        <= '0;
			dst_q        <= '0;
			wdst_s1      <= '0;
			up_q         <= 1'b0;
			avail_q      <= '0;
			res_value_q  <= '0;
			res_status_q <= isie_pkg::ST_DONE;
			rsp_q        <= '0;
		end else begin
			// Raise valid on a loaded result, drop it once taken
			if (state_q == S_FIN && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					res_value_q <= '0;
					case (mode_q)
						isie_pkg::MODE_INSERT: begin
							if (pos_q > len_x) begin
								res_status_q <= isie_pkg::ST_RANGE;
								state_q      <= S_FIN;
							end else if (len_x == CAP_X) begin
								res_status_q <= isie_pkg::ST_FULL;
								state_q      <= S_FIN;
							end else begin
								res_status_q <= isie_pkg::ST_DONE;
								left_q       <= LCNT_W'(len_x - pos_q);
								src_q        <= ADDR_W'(len_x - CMP_W'(1));
								dst_q        <= ADDR_W'(len_x);
								up_q         <= 1'b0;
								state_q      <= S_MOVE;
							end
						end
						isie_pkg::MODE_ERASE: begin
							if (pos_q >= len_x) begin
								res_status_q <= isie_pkg::ST_RANGE;
								state_q      <= S_FIN;
							end else begin
								res_status_q <= isie_pkg::ST_DONE;
								avail_q      <= len_x - pos_q;
								state_q      <= S_CLAMP;
							end
						end
						isie_pkg::MODE_GET: begin
							if (pos_q >= len_x) begin
								res_status_q <= isie_pkg::ST_RANGE;
								state_q      <= S_FIN;
							end else begin
								res_status_q <= isie_pkg::ST_DONE;
								state_q      <= S_GETRD;
							end
						end
						default: begin
							if (pos_q >= len_x) begin
								res_status_q <= isie_pkg::ST_RANGE;
							end else begin
								res_status_q <= isie_pkg::ST_DONE;
							end
							state_q <= S_FIN;
						end
					endcase
				end
				S_CLAMP: begin
					// Clamp the count and close the gap from the position upward
					if (ecnt == '0) begin
						state_q <= S_FIN;
					end else begin
						left_q  <= LCNT_W'(avail_q - ecnt);
						src_q   <= ADDR_W'(pos_q + ecnt);
						dst_q   <= pos_q[ADDR_W-1:0];
						len_q   <= LCNT_W'(len_x - ecnt);
						up_q    <= 1'b1;
						state_q <= S_MOVE;
					end
				end
				S_MOVE: begin
					// Read one entry a cycle, write it in the following cycle
					wdst_s1 <= dst_q;
					if (left_q != '0) begin
						rv_s1  <= 1'b1;
						left_q <= left_q - LCNT_W'(1);
						if (up_q) begin
							src_q <= src_q + ADDR_W'(1);
							dst_q <= dst_q + ADDR_W'(1);
						end else begin
							src_q <= src_q - ADDR_W'(1);
							dst_q <= dst_q - ADDR_W'(1);
						end
					end else begin
						rv_s1 <= 1'b0;
						if (!rv_s1) begin
							if (mode_q == isie_pkg::MODE_INSERT) begin
								len_q <= len_q + LCNT_W'(1);
							end
							state_q <= S_FIN;
						end
					end
				end
				S_GETRD: begin
					res_value_q <= ram_rdata;
					state_q     <= S_FIN;
				end
				S_FIN: begin
					// Load the result once the output register is free
					if (out_free) begin
						rsp_q.read_value <= res_value_q;
						rsp_q.length     <= len_x[isie_pkg::LEN_W-1:0];
						rsp_q.status     <= res_status_q;
						state_q          <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire
